@@ hdl/nfit_pkg.sv @@
package nfit_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int CHUNK_W         = 32;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 8;
    localparam int HANDLE_W = 32;
    localparam int GROUP_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GROUP = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

endpackage

@@ hdl/nfit_req_if.sv @@
interface nfit_req_if
    import nfit_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     slot_id;
    logic [HANDLE_W-1:0] record_handle;

    modport source (output valid, output kind, output slot_id, output record_handle,
                    input ready);
    modport sink (input valid, input kind, input slot_id, input record_handle,
                  output ready);
endinterface

@@ hdl/nfit_rsp_if.sv @@
interface nfit_rsp_if
    import nfit_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     given_id;
    logic [HANDLE_W-1:0] found_handle;
    logic [GROUP_W-1:0]  group_id;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output given_id, output found_handle, output group_id,
                    output status, input ready);
    modport sink (input valid, input given_id, input found_handle, input group_id,
                  input status, output ready);
endinterface

@@ hdl/nfit_ram.sv @@
module nfit_ram
    import nfit_pkg::*;
#(
    parameter int WIDTH = HANDLE_W,
    parameter int DEPTH = TABLE_SLOTS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/next_fit_id_table_core.sv @@
// flow: requests are accepted only in ST_IDLE; each passes ST_SCAN, then ST_FIN, where
//   its result word is registered once the previous one is taken; these states serve
//   the two-level search (per-chunk priority encode, then chunk pick) and the ram read
// reset: occupancy bits clear at once, so the table reads empty with no clearing pass;
//   next-fit pointer and group counter start at 1
module next_fit_id_table_core
    import nfit_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    nfit_req_if.sink   req,
    nfit_rsp_if.source rsp
);

    localparam int AW     = $clog2(TABLE_SLOTS);
    localparam int NCHUNK = (TABLE_SLOTS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CW     = $clog2(CHUNK_W);
    localparam int NCW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [ID_W-1:0]     slot_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [AW-1:0]       ptr_reg;
    logic [GROUP_W-1:0]  grp_reg, grp_next;
    logic [TABLE_SLOTS-1:0] occ_reg;

    logic                rsp_valid_reg;
    logic [ID_W-1:0]     given_reg;
    logic [HANDLE_W-1:0] found_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic [STATUS_W-1:0] status_reg;

    // per-chunk search summary
    logic [NCHUNK-1:0]   hi_any_reg, lo_any_reg;
    logic [CW-1:0]       hi_off_reg [NCHUNK];
    logic [CW-1:0]       lo_off_reg [NCHUNK];
    logic [NCHUNK-1:0]   hi_any_c, lo_any_c;
    logic [CW-1:0]       hi_off_c [NCHUNK];
    logic [CW-1:0]       lo_off_c [NCHUNK];

    logic                accept, finish, id_ok, occ_hit;
    logic [AW-1:0]       addr;
    logic [HANDLE_W-1:0] rdata;
    logic                ram_we;

    logic                pick_ok;
    logic [NCW-1:0]      pick_chunk;
    logic [CW-1:0]       pick_off;
    logic [AW-1:0]       pick_id;
    logic [AW:0]         ptr_sum;
    logic [AW-1:0]       ptr_next;

    logic [ID_W-1:0]     given_next;
    logic [HANDLE_W-1:0] found_next;
    logic [GROUP_W-1:0]  group_next;
    logic [STATUS_W-1:0] status_next;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign finish  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp.ready);

    assign addr    = AW'(slot_reg);
    assign id_ok   = (slot_reg != '0) && (32'(slot_reg) < 32'(TABLE_SLOTS));
    assign occ_hit = occ_reg[addr];

    assign ram_we  = finish && (kind_reg == KIND_STORE) && id_ok && (handle_reg != '0);

    nfit_ram #(
        .WIDTH(HANDLE_W),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr),
        .wdata(handle_reg),
        .raddr(addr),
        .rdata(rdata)
    );

    // first stage: free bits at or above the pointer, and free bits anywhere but slot 0
    always_comb
    begin
        logic [PAD_W-1:0] free_pad;
        logic [PAD_W-1:0] hi_pad;
        free_pad = '0;
        hi_pad   = '0;
        for (int i = 1; i < PAD_W; i++)
        begin
            if (i < TABLE_SLOTS)
            begin
                free_pad[i] = !occ_reg[AW'(i)];
            end
            hi_pad[i] = free_pad[i] && (i >= int'(ptr_reg));
        end
        for (int c = 0; c < NCHUNK; c++)
        begin
            hi_any_c[c] = |hi_pad[c*CHUNK_W +: CHUNK_W];
            lo_any_c[c] = |free_pad[c*CHUNK_W +: CHUNK_W];
            hi_off_c[c] = '0;
            lo_off_c[c] = '0;
            for (int b = CHUNK_W - 1; b >= 0; b--)
            begin
                if (hi_pad[c*CHUNK_W + b])
                begin
                    hi_off_c[c] = CW'(b);
                end
                if (free_pad[c*CHUNK_W + b])
                begin
                    lo_off_c[c] = CW'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_any_reg <= hi_any_c;
        lo_any_reg <= lo_any_c;
        hi_off_reg <= hi_off_c;
        lo_off_reg <= lo_off_c;
    end

    // second stage: lowest chunk above the pointer, else lowest chunk overall (wrap)
    always_comb
    begin
        logic           hi_found, lo_found;
        logic [NCW-1:0] hi_c, lo_c;
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_c     = '0;
        lo_c     = '0;
        for (int c = NCHUNK - 1; c >= 0; c--)
        begin
            if (hi_any_reg[c])
            begin
                hi_found = 1'b1;
                hi_c     = NCW'(c);
            end
            if (lo_any_reg[c])
            begin
                lo_found = 1'b1;
                lo_c     = NCW'(c);
            end
        end
        if (hi_found)
        begin
            pick_chunk = hi_c;
            pick_off   = hi_off_reg[hi_c];
        end
        else
        begin
            pick_chunk = lo_c;
            pick_off   = lo_off_reg[lo_c];
        end
        pick_ok = hi_found || lo_found;
    end

    assign pick_id  = AW'({pick_chunk, pick_off});
    assign ptr_sum  = {1'b0, pick_id} + (AW+1)'(1);
    assign ptr_next = (ptr_sum >= (AW+1)'(TABLE_SLOTS)) ? AW'(1) : ptr_sum[AW-1:0];

    assign grp_next = (grp_reg == '1) ? GROUP_W'(1) : grp_reg + GROUP_W'(1);

    always_comb
    begin
        given_next  = '0;
        found_next  = '0;
        group_next  = '0;
        status_next = STAT_DONE;
        case (kind_reg)
            KIND_ALLOC:
            begin
                if (pick_ok)
                begin
                    given_next = ID_W'(pick_id);
                end
                else
                begin
                    status_next = STAT_NOFREE;
                end
            end
            KIND_STORE:
            begin
                if (!id_ok || handle_reg == '0)
                begin
                    status_next = STAT_IGNORED;
                end
            end
            KIND_CLEAR:
            begin
                if (!id_ok)
                begin
                    status_next = STAT_IGNORED;
                end
            end
            KIND_LOOK:
            begin
                if (!id_ok)
                begin
                    status_next = STAT_IGNORED;
                end
                else if (occ_hit)
                begin
                    found_next = rdata;
                end
            end
            KIND_GROUP:
            begin
                group_next = grp_reg;
            end
            default:
            begin
                status_next = STAT_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req.kind;
            slot_reg   <= req.slot_id;
            handle_reg <= req.record_handle;
        end
        if (finish)
        begin
            given_reg  <= given_next;
            found_reg  <= found_next;
            group_reg  <= group_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= AW'(1);
            grp_reg       <= GROUP_W'(1);
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (finish && kind_reg == KIND_ALLOC && pick_ok)
            begin
                ptr_reg <= ptr_next;
            end
            if (finish && kind_reg == KIND_GROUP)
            begin
                grp_reg <= grp_next;
            end
            if (ram_we)
            begin
                occ_reg[addr] <= 1'b1;
            end
            if (finish && kind_reg == KIND_CLEAR && id_ok)
            begin
                occ_reg[addr] <= 1'b0;
            end
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.given_id     = given_reg;
    assign rsp.found_handle = found_reg;
    assign rsp.group_id     = group_reg;
    assign rsp.status       = status_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import nfit_pkg::*;

    localparam int                 SLOTS      = TABLE_SLOTS_DEF;
    localparam int                 N_ITEMS    = 1550;
    localparam int                 IDLE_LIMIT = 2000;
    localparam int                 DRAIN_CYC  = 10;
    localparam logic [KIND_W-1:0]  KIND_LAST  = '1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     slot_id;
        logic [HANDLE_W-1:0] record_handle;
    } table_req_t;

    typedef struct packed {
        logic [ID_W-1:0]     given_id;
        logic [HANDLE_W-1:0] found_handle;
        logic [GROUP_W-1:0]  group_id;
        logic [STATUS_W-1:0] status;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    nfit_req_if req_if ();
    nfit_rsp_if rsp_if ();

    next_fit_id_table_core #(
        .TABLE_SLOTS (SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // shadow copy of the id table
    logic [HANDLE_W-1:0] shadow_handles [SLOTS];
    int                  shadow_ptr = 1;
    logic [GROUP_W-1:0]  shadow_group = 1;

    table_req_t request_words [$];
    table_rsp_t expected_replies [$];
    int         n_issued  = 0;
    int         err_count = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++)
            shadow_handles[i] = '0;
    end

    function automatic bit slot_valid(input logic [ID_W-1:0] id);
        return id != 0 && int'(id) < SLOTS;
    endfunction

    // next-fit search: upward from the pointer, then wrap to 1 below it
    function automatic int next_fit_search();
        int id;
        id = shadow_ptr;
        while (id < SLOTS && shadow_handles[id] != 0)
            id++;
        if (id >= SLOTS)
        begin
            id = 1;
            while (id < shadow_ptr && shadow_handles[id] != 0)
                id++;
            if (id >= shadow_ptr)
                return 0;
        end
        shadow_ptr = id + 1;
        if (shadow_ptr >= SLOTS)
            shadow_ptr = 1;
        return id;
    endfunction

    function automatic table_rsp_t predict_table_op(input table_req_t w);
        table_rsp_t r;
        int         id;
        r = '0;
        r.status = STAT_DONE;
        case (w.kind)
            KIND_ALLOC:
            begin
                id = next_fit_search();
                r.given_id = id[ID_W-1:0];
                if (id == 0)
                    r.status = STAT_NOFREE;
            end
            KIND_STORE:
            begin
                if (w.record_handle == 0 || !slot_valid(w.slot_id))
                    r.status = STAT_IGNORED;
                else
                    shadow_handles[w.slot_id] = w.record_handle;
            end
            KIND_CLEAR:
            begin
                if (!slot_valid(w.slot_id))
                    r.status = STAT_IGNORED;
                else
                    shadow_handles[w.slot_id] = '0;
            end
            KIND_LOOK:
            begin
                if (!slot_valid(w.slot_id))
                    r.status = STAT_IGNORED;
                else
                    r.found_handle = shadow_handles[w.slot_id];
            end
            KIND_GROUP:
            begin
                r.group_id = shadow_group;
                shadow_group = shadow_group + 1;
                if (shadow_group == 0)
                    shadow_group = 1;
            end
            default:
                r.status = STAT_IGNORED;
        endcase
        return r;
    endfunction

    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [HANDLE_W-1:0] handle,
                                 output logic [ID_W-1:0] given);
        table_req_t w;
        table_rsp_t r;
        w.kind          = kind;
        w.slot_id       = id;
        w.record_handle = handle;
        r = predict_table_op(w);
        request_words.push_back(w);
        expected_replies.push_back(r);
        given = r.given_id;
        n_issued++;
    endtask

    function automatic logic [ID_W-1:0] rand_slot();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return ID_W'($urandom_range(1, SLOTS - 1));
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return HANDLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] live_handle();
        logic [HANDLE_W-1:0] h;
        h = HANDLE_W'($urandom);
        if (h == 0)
            h = 1;
        return h;
    endfunction

    // one random step; clr_weight shifts the balance between filling and draining
    task automatic random_step(input int clr_weight);
        logic [ID_W-1:0] gid;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // well-formed allocate then store into the id given out
            issue_request(KIND_ALLOC, rand_slot(), rand_handle(), gid);
            if (gid != 0)
                issue_request(KIND_STORE, gid, live_handle(), gid);
        end
        else if (pick < 35 + clr_weight)
            issue_request(KIND_CLEAR, rand_slot(), rand_handle(), gid);
        else if (pick < 55 + clr_weight)
            issue_request(KIND_LOOK, rand_slot(), rand_handle(), gid);
        else if (pick < 67 + clr_weight)
            issue_request(KIND_STORE, rand_slot(), rand_handle(), gid);
        else if (pick < 76 + clr_weight)
            issue_request(KIND_GROUP, rand_slot(), rand_handle(), gid);
        else if (pick < 80 + clr_weight)
            issue_request(KIND_W'($urandom_range(KIND_GROUP + 1, KIND_LAST)), rand_slot(),
                          rand_handle(), gid);
        else
            issue_request(KIND_ALLOC, rand_slot(), rand_handle(), gid);
    endtask

    // driver: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        table_req_t w;
        if (!rst_n)
        begin
            req_if.valid         <= 1'b0;
            req_if.kind          <= '0;
            req_if.slot_id       <= '0;
            req_if.record_handle <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_if.valid <= 1'b0;
            end
            else if (request_words.size() > 0)
            begin
                w = request_words.pop_front();
                req_if.valid         <= 1'b1;
                req_if.kind          <= w.kind;
                req_if.slot_id       <= w.slot_id;
                req_if.record_handle <= w.record_handle;
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // receiver stall pattern, rotated every cycle and reloaded now and then
    logic [15:0] stall_pat;
    int          pat_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_pat = '1;
            pat_left  = 0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom) | 16'($urandom);
                    default:
                    begin
                        stall_pat = 16'($urandom) & 16'($urandom);
                        if (stall_pat == 0)
                            stall_pat = 16'h0001;
                    end
                endcase
                pat_left = $urandom_range(16, 96);
            end
            pat_left--;
            rsp_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    // monitor: compare each reply word with the oldest prediction
    always @(posedge clk)
    begin
        table_rsp_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply word given_id %0d found_handle %h group_id %h status %0d",
                         $time, rsp_if.given_id, rsp_if.found_handle, rsp_if.group_id,
                         rsp_if.status);
                err_count++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (rsp_if.given_id !== exp_r.given_id)
                begin
                    $display("%0t: given_id expected %0d actual %0d", $time,
                             exp_r.given_id, rsp_if.given_id);
                    err_count++;
                end
                if (rsp_if.found_handle !== exp_r.found_handle)
                begin
                    $display("%0t: found_handle expected %h actual %h", $time,
                             exp_r.found_handle, rsp_if.found_handle);
                    err_count++;
                end
                if (rsp_if.group_id !== exp_r.group_id)
                begin
                    $display("%0t: group_id expected %h actual %h", $time,
                             exp_r.group_id, rsp_if.group_id);
                    err_count++;
                end
                if (rsp_if.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, rsp_if.status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [ID_W-1:0] gid;

        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = '0;
        req_if.slot_id       = '0;
        req_if.record_handle = '0;
        rsp_if.ready         = 1'b0;

        // directed: empty and invalid slots, extremes, every kind
        issue_request(KIND_LOOK, 8'd1, '0, gid);
        issue_request(KIND_LOOK, '0, '1, gid);
        issue_request(KIND_STORE, '0, 32'h0000_0005, gid);
        issue_request(KIND_STORE, 8'd5, '0, gid);
        issue_request(KIND_CLEAR, '0, '1, gid);
        issue_request(KIND_ALLOC, '0, '0, gid);
        issue_request(KIND_STORE, gid, '1, gid);
        issue_request(KIND_LOOK, 8'd1, '0, gid);
        issue_request(KIND_ALLOC, '1, '1, gid);
        issue_request(KIND_STORE, '1, 32'h8000_0001, gid);
        issue_request(KIND_LOOK, '1, '0, gid);
        issue_request(KIND_CLEAR, '1, '0, gid);
        issue_request(KIND_LOOK, '1, '1, gid);
        issue_request(KIND_STORE, 8'd128, 32'h5A5A_5A5A, gid);
        issue_request(KIND_LOOK, 8'd128, '0, gid);
        issue_request(KIND_CLEAR, 8'd128, '0, gid);
        issue_request(KIND_GROUP, '1, '1, gid);
        issue_request(KIND_GROUP, '0, '0, gid);
        for (int k = KIND_GROUP + 1; k <= KIND_LAST; k++)
            issue_request(KIND_W'(k), '1, '1, gid);
        issue_request(KIND_ALLOC, '0, '0, gid);

        // random mix
        while (n_issued < 450)
            random_step(15);

        // fill the table until allocation runs dry
        while (1)
        begin
            issue_request(KIND_ALLOC, rand_slot(), rand_handle(), gid);
            if (gid == 0)
                break;
            issue_request(KIND_STORE, gid, live_handle(), gid);
            if ($urandom_range(0, 7) == 0)
                issue_request(KIND_LOOK, rand_slot(), '0, gid);
        end
        issue_request(KIND_ALLOC, '0, '0, gid);
        issue_request(KIND_GROUP, '0, '0, gid);
        issue_request(KIND_ALLOC, '1, '1, gid);

        // punch holes, then allocate across the wrap
        repeat (40)
            issue_request(KIND_CLEAR, ID_W'($urandom_range(1, SLOTS - 1)), '0, gid);
        repeat (30)
        begin
            issue_request(KIND_ALLOC, '0, '0, gid);
            if (gid != 0)
                issue_request(KIND_STORE, gid, live_handle(), gid);
        end

        while (n_issued < N_ITEMS)
            random_step(25);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_words.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/nfit_pkg.sv
hdl/nfit_req_if.sv
hdl/nfit_rsp_if.sv
hdl/nfit_ram.sv
hdl/next_fit_id_table_core.sv
test/tb.sv
